>>> hw/rtl/gjyd_pkg.sv
package gjyd_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_YEAR  = 2'd1;
   localparam logic [1:0] STATUS_BAD_MONTH = 2'd2;
   localparam logic [1:0] STATUS_BAD_DAY   = 2'd3;

   // field widths
   localparam int unsigned YEAR_IN_W  = 14;
   localparam int unsigned YEAR_W     = 15;
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 6;
   localparam int unsigned DOY_W      = 9;
   localparam int unsigned DAYNUM_W   = 23;
   localparam int unsigned QUAD_W     = 13;
   localparam int unsigned REM_W      = 11;

   // earliest year accepted after century widening
   localparam logic signed [YEAR_W-1:0] MIN_YEAR = -15'sd4711;

   // offsets of the day-number formula
   localparam logic [YEAR_W-1:0] YEAR_BIAS     = 15'd4800;
   localparam logic [13:0]       CENTURY_BIAS  = 14'd100;
   localparam logic [23:0]       DAYNUM_OFFSET = 24'd30661;
   localparam logic [10:0]       DAYS_PER_QUAD = 11'd1461;
   localparam logic [10:0]       DAYS_PER_YEAR = 11'd365;
   localparam logic [YEAR_W-1:0] JULIAN_EPOCH  = 15'd4716;

   // reciprocal of 100 for 14-bit dividends: q = (x * RECIP_100) >> SHIFT_100
   localparam int unsigned SHIFT_100 = 21;
   localparam logic [14:0] RECIP_100 =
      15'(((64'd1 << SHIFT_100) + 64'd99) / 64'd100);

   // reciprocal of 1461 for 23-bit dividends
   localparam int unsigned SHIFT_1461 = 34;
   localparam logic [23:0] RECIP_1461 =
      24'(((64'd1 << SHIFT_1461) + 64'd1460) / 64'd1461);

   // day-in-year offset from 80*x/2447/11: set once x reaches this threshold
   localparam logic [8:0] MONTH_FIX_T = 9'(((11 * 2447) + 79) / 80 - 30);

   // day number handed from the front half to the back half
   typedef struct packed {
      logic [DAYNUM_W-1:0] dn_m1;
      logic [1:0]          status;
   } gjyd_daynum_type;

   // days in month, common year
   function automatic logic [4:0] gjyd_month_len(input logic [MONTH_W-1:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // month term of the day number, months counted from March
   function automatic logic [8:0] gjyd_month_term(input logic [MONTH_W-1:0] month);
      logic [8:0] term;
      unique case (month)
         4'd3:    term = 9'd30;
         4'd4:    term = 9'd61;
         4'd5:    term = 9'd91;
         4'd6:    term = 9'd122;
         4'd7:    term = 9'd152;
         4'd8:    term = 9'd183;
         4'd9:    term = 9'd214;
         4'd10:   term = 9'd244;
         4'd11:   term = 9'd275;
         4'd12:   term = 9'd305;
         4'd1:    term = 9'd336;
         4'd2:    term = 9'd367;
         default: term = 9'd0;
      endcase
      return term;
   endfunction

endpackage

>>> hw/rtl/gjyd_date_to_daynum.sv
module gjyd_date_to_daynum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         century_default_enable,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic signed [13:0]           in_greg_year,
   input  logic [3:0]                   in_greg_month,
   input  logic [5:0]                   in_greg_day,
   output logic                         out_valid,
   input  logic                         out_stall,
   output gjyd_pkg::gjyd_daynum_type    out_daynum
);
   import gjyd_pkg::*;

   // stage enables: a stage moves when it is empty or the next one moves
   logic en1, en2, en3;

   // stage 1 registers
   logic                s1_valid_ff;
   logic [13:0]         s1_kp48_ff, s1_kp48_in;
   logic [13:0]         s1_yp48_ff, s1_yp48_in;
   logic [8:0]          s1_mterm_ff;
   logic [4:0]          s1_mlen_ff;
   logic                s1_feb_ff;
   logic [DAY_W-1:0]    s1_day_ff;
   logic [1:0]          s1_status_ff, s1_status_in;

   // stage 2 registers
   logic                s2_valid_ff;
   logic [DAYNUM_W-1:0] s2_a_ff, s2_a_in;
   logic [7:0]          s2_qk_ff, s2_qk_in;
   logic [7:0]          s2_qy_ff, s2_qy_in;
   logic [13:0]         s2_yp48_ff;
   logic [8:0]          s2_mterm_ff;
   logic [4:0]          s2_mlen_ff;
   logic                s2_feb_ff;
   logic [DAY_W-1:0]    s2_day_ff;
   logic [1:0]          s2_status_ff;

   // stage 3 registers
   logic                s3_valid_ff;
   gjyd_daynum_type     s3_daynum_ff, s3_daynum_in;

   logic [YEAR_W-1:0]   year_w;
   logic                jan_feb;
   logic [YEAR_W-1:0]   kp48_w;
   logic [YEAR_W-1:0]   yp48_w;
   logic [24:0]         a_prod;
   logic [13:0]         kp49;
   logic [28:0]         qk_prod;
   logic [28:0]         qy_prod;
   logic [9:0]          c_prod;
   logic [13:0]         r100;
   logic                leap;
   logic [4:0]          mlen_eff;
   logic                bad_day;
   logic [23:0]         dn_sum;

   // handshake chain
   assign en3      = !s3_valid_ff || !out_stall;
   assign en2      = !s2_valid_ff || en3;
   assign en1      = !s1_valid_ff || en2;
   assign in_stall = !en1;

   // stage 0: century widening, range checks, year offsets
   always_comb begin
      year_w = {in_greg_year[13], in_greg_year};
      priority if (century_default_enable && !in_greg_year[13]
                   && in_greg_year[12:0] <= 13'd49) begin
         year_w = year_w + 15'd2000;
      end else if (century_default_enable && !in_greg_year[13]
                   && in_greg_year[12:0] <= 13'd99) begin
         year_w = year_w + 15'd1900;
      end else begin
         year_w = year_w;
      end
      jan_feb = (in_greg_month == 4'd1) || (in_greg_month == 4'd2);
      kp48_w  = year_w + YEAR_BIAS - {14'd0, jan_feb};
      yp48_w  = year_w + YEAR_BIAS;
      s1_kp48_in = kp48_w[13:0];
      s1_yp48_in = yp48_w[13:0];
      priority if ($signed(year_w) < MIN_YEAR) begin
         s1_status_in = STATUS_BAD_YEAR;
      end else if (in_greg_month == 4'd0 || in_greg_month > 4'd12) begin
         s1_status_in = STATUS_BAD_MONTH;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_kp48_ff   <= s1_kp48_in;
         s1_yp48_ff   <= s1_yp48_in;
         s1_mterm_ff  <= gjyd_month_term(in_greg_month);
         s1_mlen_ff   <= gjyd_month_len(in_greg_month);
         s1_feb_ff    <= (in_greg_month == 4'd2);
         s1_day_ff    <= in_greg_day;
         s1_status_ff <= s1_status_in;
      end
   end

   // stage 1: year term and the two divisions by 100
   always_comb begin
      a_prod   = 25'(s1_kp48_ff) * 25'(DAYS_PER_QUAD);
      s2_a_in  = a_prod[24:2];
      kp49     = s1_kp48_ff + CENTURY_BIAS;
      qk_prod  = 29'(kp49) * 29'(RECIP_100);
      qy_prod  = 29'(s1_yp48_ff) * 29'(RECIP_100);
      s2_qk_in = qk_prod[28:SHIFT_100];
      s2_qy_in = qy_prod[28:SHIFT_100];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_a_ff      <= s2_a_in;
         s2_qk_ff     <= s2_qk_in;
         s2_qy_ff     <= s2_qy_in;
         s2_yp48_ff   <= s1_yp48_ff;
         s2_mterm_ff  <= s1_mterm_ff;
         s2_mlen_ff   <= s1_mlen_ff;
         s2_feb_ff    <= s1_feb_ff;
         s2_day_ff    <= s1_day_ff;
         s2_status_ff <= s1_status_ff;
      end
   end

   // stage 2: leap rule, day check, day number sum
   always_comb begin
      c_prod   = 10'(s2_qk_ff) * 10'd3;
      r100     = s2_yp48_ff - 14'(s2_qy_ff) * 14'd100;
      leap     = (s2_yp48_ff[1:0] == 2'd0) && ((r100 != 14'd0) || (s2_qy_ff[1:0] == 2'd0));
      mlen_eff = (s2_feb_ff && leap) ? 5'd29 : s2_mlen_ff;
      bad_day  = (s2_day_ff == 6'd0) || (s2_day_ff > {1'b0, mlen_eff});
      dn_sum   = 24'(s2_a_ff) + 24'(s2_mterm_ff) + 24'(s2_day_ff)
               - 24'(c_prod[9:2]) - DAYNUM_OFFSET;
      s3_daynum_in.dn_m1  = dn_sum[DAYNUM_W-1:0];
      s3_daynum_in.status = (s2_status_ff == STATUS_OK && bad_day) ? STATUS_BAD_DAY
                                                                   : s2_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_daynum_ff <= s3_daynum_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_daynum = s3_daynum_ff;

`ifndef SYNTH
   // the front half only pushes back when every stage is occupied
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("front half stalls with an empty stage");

   // a held day number survives the stall
   a_hold_daynum: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && out_stall) |=> (s3_valid_ff && $stable(s3_daynum_ff)))
      else $error("day number changed while stalled");
`endif

endmodule

>>> hw/rtl/gjyd_daynum_split.sv
module gjyd_daynum_split (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  gjyd_pkg::gjyd_daynum_type    in_daynum,
   output logic                         out_valid,
   input  logic                         out_stall,
   output logic signed [14:0]           out_julian_year,
   output logic [8:0]                   out_day_of_year,
   output logic [1:0]                   out_status
);
   import gjyd_pkg::*;

   logic en4, en5, en6;

   // stage 4: four-year cycle count
   logic                s4_valid_ff;
   logic [DAYNUM_W-1:0] s4_dn_m1_ff;
   logic [QUAD_W-1:0]   s4_quad_ff, s4_quad_in;
   logic [1:0]          s4_status_ff;

   // stage 5: day within the four-year cycle
   logic                s5_valid_ff;
   logic [QUAD_W-1:0]   s5_quad_ff;
   logic [REM_W-1:0]    s5_rem_ff, s5_rem_in;
   logic [1:0]          s5_status_ff;

   // stage 6: result register
   logic                out_valid_ff;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [DOY_W-1:0]    doy_ff, doy_in;
   logic [1:0]          status_ff;

   logic [46:0]         quad_prod;
   logic [23:0]         rem_prod;
   logic [23:0]         rem_w;
   logic [REM_W-1:0]    rm1;
   logic [2:0]          n0;
   logic [1:0]          n;
   logic [REM_W-1:0]    t_w;
   logic [8:0]          t;
   logic                mfix;
   logic [9:0]          nd_w;
   logic [YEAR_W-1:0]   ny_w;

   assign en6      = !out_valid_ff || !out_stall;
   assign en5      = !s5_valid_ff || en6;
   assign en4      = !s4_valid_ff || en5;
   assign in_stall = !en4;

   // stage 3 to 4: divide by 1461 through the reciprocal
   always_comb begin
      quad_prod  = 47'(in_daynum.dn_m1) * 47'(RECIP_1461);
      s4_quad_in = quad_prod[46:SHIFT_1461];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_dn_m1_ff  <= in_daynum.dn_m1;
         s4_quad_ff   <= s4_quad_in;
         s4_status_ff <= in_daynum.status;
      end
   end

   // stage 4 to 5: remainder, 1..1461
   always_comb begin
      rem_prod  = 24'(s4_quad_ff) * 24'(DAYS_PER_QUAD);
      rem_w     = 24'(s4_dn_m1_ff) + 24'd1 - rem_prod;
      s5_rem_in = rem_w[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en5) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_quad_ff   <= s4_quad_ff;
         s5_rem_ff    <= s5_rem_in;
         s5_status_ff <= s4_status_ff;
      end
   end

   // stage 5 to 6: year in cycle, month fix-up, day in year
   always_comb begin
      rm1  = s5_rem_ff - 11'd1;
      n0   = 3'(rm1 >= 11'd365) + 3'(rm1 >= 11'd730)
           + 3'(rm1 >= 11'd1095) + 3'(rm1 >= 11'd1460);
      n    = 2'(n0 - 3'(s5_rem_ff == DAYS_PER_QUAD));
      t_w  = s5_rem_ff - 11'(DAYS_PER_YEAR * 11'(n));
      t    = t_w[8:0];
      mfix = (t >= MONTH_FIX_T);
      nd_w = 10'd59 + 10'(t) - (mfix ? 10'(DAYS_PER_YEAR) : 10'd0)
           + 10'(n == 2'd0 && !mfix);
      ny_w = {s5_quad_ff[QUAD_W-1:0], 2'b00} + 15'(n) + 15'(mfix) - JULIAN_EPOCH;
      if (s5_status_ff == STATUS_BAD_YEAR || s5_status_ff == STATUS_BAD_MONTH) begin
         year_in = '0;
         doy_in  = '0;
      end else begin
         year_in = ny_w;
         doy_in  = nd_w[DOY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en6) begin
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         year_ff   <= year_in;
         doy_ff    <= doy_in;
         status_ff <= s5_status_ff;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_julian_year = $signed(year_ff);
   assign out_day_of_year = doy_ff;
   assign out_status      = status_ff;

`ifndef SYNTH
   // remainder of the reciprocal division always lands in 1..1461, within the four-year cycle
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (s5_rem_ff >= 11'd1 && s5_rem_ff <= DAYS_PER_QUAD))
      else $error("four-year remainder out of range");

   // rejected dates carry zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (status_ff == STATUS_BAD_YEAR || status_ff == STATUS_BAD_MONTH))
      |-> (year_ff == '0 && doy_ff == '0))
      else $error("rejected date has nonzero fields");

   // converted dates give a day in 1..366
   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (status_ff == STATUS_OK || status_ff == STATUS_BAD_DAY))
      |-> (doy_ff >= 9'd1 && doy_ff <= 9'd366))
      else $error("day in year out of range");
`endif

endmodule

>>> hw/rtl/gregorian_to_julian_year_day_unit.sv
// Gregorian date to year and day-in-year of a Julian calendar aligned to the
// 20th/21st century.
//
// Request channel (req_valid / req_stall): one date per transaction, taken at
// an edge with req_valid high and req_stall low. Response channel (rsp_valid /
// rsp_stall): one result per request, in order.
// Control register (csr_valid / csr_ready / csr_wdata): century default
// enable, 1 after reset; csr_ready is always high. Write only while idle.
//
// Pipeline: six register stages. Throughput: one date per cycle while rsp_stall
// is low, set by the six-stage pipeline (day number in three stages, then the
// reciprocal divide by 1461, the remainder and the year split in three more).
// When rsp_stall holds a result, upstream stages keep filling empty slots and
// req_stall rises only once every stage holds a transaction; nothing is lost
// or repeated. Reset empties the pipeline and sets the century default on.
module gregorian_to_julian_year_day_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [13:0] req_greg_year,
   input  logic [3:0]         req_greg_month,
   input  logic [5:0]         req_greg_day,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_julian_year,
   output logic [8:0]         rsp_day_of_year,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);
   import gjyd_pkg::*;

   logic            century_en_ff;
   logic            mid_valid;
   logic            mid_stall;
   gjyd_daynum_type mid_daynum;

   // control register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         century_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         century_en_ff <= csr_wdata;
      end
   end

   // date to day number
   gjyd_date_to_daynum u_front (
      .clock                  (clock),
      .reset                  (reset),
      .century_default_enable (century_en_ff),
      .in_valid               (req_valid),
      .in_stall               (req_stall),
      .in_greg_year           (req_greg_year),
      .in_greg_month          (req_greg_month),
      .in_greg_day            (req_greg_day),
      .out_valid              (mid_valid),
      .out_stall              (mid_stall),
      .out_daynum             (mid_daynum)
   );

   // day number to year and day in year
   gjyd_daynum_split u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (mid_valid),
      .in_stall        (mid_stall),
      .in_daynum       (mid_daynum),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_julian_year (rsp_julian_year),
      .out_day_of_year (rsp_day_of_year),
      .out_status      (rsp_status)
   );

endmodule
